/* sv/hipl_pkg.sv */
// Shared types and constants of the HTTP IP-list response parser.
`default_nettype none

package hipl_pkg;

   typedef enum logic [1:0] {
      KIND_IP_CHAR = 2'd0,
      KIND_IP_END  = 2'd1,
      KIND_SUMMARY = 2'd2
   } hipl_kind_type;

   typedef enum logic [2:0] {
      PH_STATUS = 3'd0,
      PH_HEADER = 3'd1,
      PH_PRE    = 3'd2,
      PH_IP     = 3'd3,
      PH_TTL    = 3'd4,
      PH_DONE   = 3'd5
   } hipl_phase_type;

   typedef enum logic [1:0] {
      TS_PRE    = 2'd0,
      TS_WS     = 2'd1,
      TS_DIGITS = 2'd2,
      TS_END    = 2'd3
   } hipl_ttl_stage_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } hipl_req_type;

   typedef struct packed {
      hipl_kind_type      kind;
      logic [7:0]         char_value;
      logic [4:0]         ip_index;
      logic               status_ok;
      logic [4:0]         ip_count;
      logic signed [31:0] ttl_value;
      logic               last;
   } hipl_rsp_type;

   // Up to two results come out of one input byte, in this order.
   typedef struct packed {
      logic         first_vld;
      hipl_rsp_type first;
      logic         second_vld;
      hipl_rsp_type second;
   } hipl_push_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   localparam logic [1:0]  MATCH_LAST = 2'd3;
   localparam logic [31:0] TTL_CAP    = 32'h8000_0000;
   localparam logic [31:0] TTL_MAX    = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

/* sv/hipl_parser.sv */
// Per-byte parse state and result generation of the response parser.
`default_nettype none

module hipl_parser
   import hipl_pkg::*;
#(
   parameter int MAX_IPS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire hipl_req_type  req,
   output hipl_push_type      push
);

   localparam int CNT_W = $clog2(MAX_IPS + 1);

   hipl_phase_type     phase_ff, phase_st, phase_in;
   hipl_ttl_stage_type ttl_stage_ff, ttl_stage_st, ttl_stage_in;
   logic [1:0]         match_ff, match_st, match_in;
   logic               found_ff, found_st, found_in;
   logic               colon_ff, colon_st, colon_in;
   logic               nonempty_ff, nonempty_st, nonempty_in;
   logic               token_ff, token_st, token_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_st, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_st, idx_in;
   logic [31:0]        acc_ff, acc_st, acc_in;
   logic               neg_ff, neg_st, neg_in;

   logic [7:0]  b;
   logic        eod;
   logic        zero_hit;
   logic        is_comma;
   logic        is_semi;
   logic        is_digit;
   logic        is_sign;
   logic        is_ws;
   logic        in_ip;
   logic        close_evt;
   logic        char_evt;
   logic        open_evt;
   logic [35:0] acc_wide;
   logic [31:0] acc_mul;
   logic [31:0] ttl_out;

   assign b        = req.data_byte;
   assign eod      = req.end_of_data;
   assign zero_hit = (b == CH_NUL) && (phase_ff != PH_DONE);
   assign is_comma = (b == CH_COMMA);
   assign is_semi  = (b == CH_SEMI);
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
   assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

   // A byte reaches the ip list in the body, or ends the leading commas.
   assign in_ip     = !zero_hit &&
                      ((phase_ff == PH_IP) || ((phase_ff == PH_PRE) && !is_comma));
   assign close_evt = token_ff &&
                      ((zero_hit && (phase_ff == PH_IP)) || (in_ip && (is_comma || is_semi)));
   assign char_evt  = in_ip && !is_comma && !is_semi;
   assign open_evt  = char_evt && !token_ff;

   // acc * 10 + digit; the low nibble of an ASCII digit is its value
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {32'b0, b[3:0]};
   assign acc_mul  = (acc_wide > {4'b0, TTL_CAP}) ? TTL_CAP : acc_wide[31:0];

   // next state
   always_comb begin
      phase_st     = phase_ff;
      ttl_stage_st = ttl_stage_ff;
      match_st     = match_ff;
      found_st     = found_ff;
      colon_st     = colon_ff;
      nonempty_st  = nonempty_ff;
      token_st     = token_ff;
      cnt_st       = cnt_ff;
      idx_st       = idx_ff;
      acc_st       = acc_ff;
      neg_st       = neg_ff;
      if (zero_hit) begin
         phase_st = PH_DONE;
      end else begin
         case (phase_ff)
            PH_STATUS: begin
               if (b == CH_NL) begin
                  if (nonempty_ff) begin
                     phase_st = found_ff ? PH_HEADER : PH_DONE;
                  end
                  nonempty_st = 1'b0;
                  colon_st    = 1'b0;
               end else begin
                  nonempty_st = 1'b1;
                  if (!found_ff) begin
                     if (match_ff == 2'd0) begin
                        match_st = (b == CH_TWO) ? 2'd1 : 2'd0;
                     end else if ((match_ff != MATCH_LAST) && (b == CH_ZERO)) begin
                        match_st = match_ff + 2'd1;
                     end else if ((match_ff == MATCH_LAST) && (b == CH_SPACE)) begin
                        found_st = 1'b1;
                        match_st = 2'd0;
                     end else begin
                        match_st = (b == CH_TWO) ? 2'd1 : 2'd0;
                     end
                  end
               end
            end
            PH_HEADER: begin
               if (b == CH_NL) begin
                  if (nonempty_ff && !colon_ff) begin
                     phase_st = PH_PRE;
                  end
                  nonempty_st = 1'b0;
                  colon_st    = 1'b0;
               end else begin
                  nonempty_st = 1'b1;
                  if (b == CH_COLON) begin
                     colon_st = 1'b1;
                  end
               end
            end
            PH_PRE: begin
               if (!is_comma) begin
                  phase_st = PH_IP;
               end
            end
            PH_IP: begin
               if (is_comma) begin
                  phase_st = PH_TTL;
               end
            end
            PH_TTL: begin
               case (ttl_stage_ff)
                  TS_PRE, TS_WS: begin
                     if (is_comma) begin
                        if (ttl_stage_ff == TS_WS) begin
                           ttl_stage_st = TS_END;
                        end
                     end else if (is_ws) begin
                        ttl_stage_st = TS_WS;
                     end else if (is_sign) begin
                        neg_st       = (b == CH_MINUS);
                        ttl_stage_st = TS_DIGITS;
                     end else if (is_digit) begin
                        acc_st       = {28'b0, b[3:0]};
                        ttl_stage_st = TS_DIGITS;
                     end else begin
                        ttl_stage_st = TS_END;
                     end
                  end
                  TS_DIGITS: begin
                     if (is_digit) begin
                        acc_st = acc_mul;
                     end else begin
                        ttl_stage_st = TS_END;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      if (close_evt) begin
         token_st = 1'b0;
      end
      if (open_evt) begin
         token_st = 1'b1;
         idx_st   = cnt_ff;
         if (cnt_ff < CNT_W'(MAX_IPS)) begin
            cnt_st = CNT_W'(cnt_ff + 1'b1);
         end
      end
   end

   // the summary returns everything to the reset values
   always_comb begin
      if (eod) begin
         phase_in     = PH_STATUS;
         ttl_stage_in = TS_PRE;
         match_in     = 2'd0;
         found_in     = 1'b0;
         colon_in     = 1'b0;
         nonempty_in  = 1'b0;
         token_in     = 1'b0;
         cnt_in       = '0;
         idx_in       = '0;
         acc_in       = '0;
         neg_in       = 1'b0;
      end else begin
         phase_in     = phase_st;
         ttl_stage_in = ttl_stage_st;
         match_in     = match_st;
         found_in     = found_st;
         colon_in     = colon_st;
         nonempty_in  = nonempty_st;
         token_in     = token_st;
         cnt_in       = cnt_st;
         idx_in       = idx_st;
         acc_in       = acc_st;
         neg_in       = neg_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STATUS;
         ttl_stage_ff <= TS_PRE;
         match_ff     <= 2'd0;
         found_ff     <= 1'b0;
         colon_ff     <= 1'b0;
         nonempty_ff  <= 1'b0;
         token_ff     <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         ttl_stage_ff <= ttl_stage_in;
         match_ff     <= match_in;
         found_ff     <= found_in;
         colon_ff     <= colon_in;
         nonempty_ff  <= nonempty_in;
         token_ff     <= token_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
      end
   end

   assign ttl_out = neg_st ? (32'd0 - acc_st) : ((acc_st > TTL_MAX) ? TTL_MAX : acc_st);

   // results
   always_comb begin
      push.first_vld        = step && (close_evt || char_evt);
      push.first.kind       = char_evt ? KIND_IP_CHAR : KIND_IP_END;
      push.first.char_value = char_evt ? b : 8'd0;
      push.first.ip_index   = 5'({{5{1'b0}}, idx_st});
      push.first.status_ok  = 1'b0;
      push.first.ip_count   = 5'({{5{1'b0}}, cnt_st});
      push.first.ttl_value  = '0;
      push.first.last       = 1'b0;

      push.second_vld        = step && eod;
      push.second.kind       = KIND_SUMMARY;
      push.second.char_value = 8'd0;
      push.second.ip_index   = 5'd0;
      push.second.status_ok  = found_st && (cnt_st != '0);
      push.second.ip_count   = 5'({{5{1'b0}}, cnt_st});
      push.second.ttl_value  = ttl_out;
      push.second.last       = 1'b1;
   end

endmodule

`default_nettype wire

/* sv/hipl_rsp_queue.sv */
// Three-entry result queue between the parser and the result channel.
`default_nettype none

module hipl_rsp_queue
   import hipl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire hipl_push_type push,
   input  wire logic          pop,
   output logic               room,
   output logic               head_vld,
   output hipl_rsp_type       head
);

   localparam int DEPTH = 3;

   hipl_rsp_type q_ff [DEPTH];
   hipl_rsp_type q_in [DEPTH];
   logic [1:0]   level_ff, level_in;
   logic [1:0]   base;
   logic [1:0]   n_push;
   logic         p0_vld;
   logic         p1_vld;
   hipl_rsp_type p0;

   assign p0_vld = push.first_vld || push.second_vld;
   assign p1_vld = push.first_vld && push.second_vld;
   assign p0     = push.first_vld ? push.first : push.second;
   assign n_push = {1'b0, p0_vld} + {1'b0, p1_vld};

   // a byte may bring two results, so take one only with two slots free
   assign room     = (level_ff <= 2'd1);
   assign head_vld = (level_ff != 2'd0);
   assign head     = q_ff[0];
   assign base     = level_ff - {1'b0, pop};
   assign level_in = base + n_push;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      if (p0_vld) begin
         q_in[base] = p0;
      end
      if (p1_vld) begin
         q_in[2'(base + 2'd1)] = push.second;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

/* sv/http_ip_list_response_parser.sv */
// HTTP IP-list response parser: byte stream in, ip characters and summary out.
//
// req_*: one response byte per transfer; end_of_data marks the final byte.
// rsp_*: one result per transfer: an ip character, the end of an ip token,
//    or the closing summary (last = 1) with status, ip count and TTL.
// Each accepted byte updates the parse state in the cycle it is accepted and
// its results land in a three-entry result queue; the queue is registered, so
// rsp_valid is high in the cycle after a byte transfer that queues a result.
// Throughput is one byte per cycle while the receiver keeps up. A byte that
// causes two results (a result plus the summary) fills two queue slots;
// req_ready drops while fewer than two queue slots are free.
// When the receiver stalls, results wait in the queue and input continues
// until the queue holds two results.
// Reset empties the queue and returns the parser to the status line; the
// summary of each response does the same for the next one.
`default_nettype none

module http_ip_list_response_parser
   import hipl_pkg::*;
#(
   parameter int MAX_IPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire hipl_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output hipl_rsp_type      rsp_data
);

   hipl_push_type push;
   logic          req_xfer;
   logic          rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   hipl_parser #(
      .MAX_IPS(MAX_IPS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .step (req_xfer),
      .req  (req_data),
      .push (push)
   );

   hipl_rsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (rsp_xfer),
      .room    (req_ready),
      .head_vld(rsp_valid),
      .head    (rsp_data)
   );

   a_eod_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.end_of_data |=> rsp_valid)
      else $error("summary not queued after final byte");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result queue");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.kind == KIND_SUMMARY)
      else $error("last flag on a non-summary result");

endmodule

`default_nettype wire
